// File: hdl/sss_pkg.sv
// Package for the sequenced sample store: sizes, codes, item and record types.
// No dependencies; used by the interfaces, the top module, the checker and the testbench.
package sss_pkg;

    localparam int NUM_STREAMS      = 16;
    localparam int SLOTS_PER_STREAM = 8;
    localparam int SID_W            = 4;
    localparam int SLOT_W           = (SLOTS_PER_STREAM > 1) ? $clog2(SLOTS_PER_STREAM) : 1;
    localparam int ADDR_W           = SID_W + SLOT_W;
    localparam int CNT_W            = $clog2(SLOTS_PER_STREAM + 1);
    localparam int REC_W            = 160;

    localparam logic [47:0] GAP_MAX = 48'hFFFF_FFFF_FFFF;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_FIND   = 2'd1;
    localparam logic [1:0] ACT_GOOD   = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [1:0] ST_FRESH = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_GAP   = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [SID_W-1:0]   stream_id;
        logic [31:0]        due_cycle;
        logic [31:0]        seq;
        logic [31:0]        payload_tag;
        logic signed [63:0] receive_time;
        logic               clock_valid;
        logic               producer_ok;
        logic               crc_ok;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               inserted;
        logic [31:0]        seq_gap;
        logic [47:0]        gap_total;
        logic               found;
        logic [31:0]        out_due_cycle;
        logic [31:0]        out_seq;
        logic [31:0]        out_payload;
        logic signed [63:0] out_receive_time;
    } out_item_t;

    typedef struct packed {
        logic [31:0] tc;
        logic [31:0] sq;
        logic [31:0] pay;
        logic [63:0] rt;
    } rec_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DECIDE,
        S_EVICT,
        S_GOOD_RD,
        S_DONE
    } state_t;

endpackage

// File: hdl/sss_if.sv
// Handshake interfaces of the sequenced sample store: request, response, config.
// Depends on sss_pkg.
interface sss_req_if;
    logic               valid;
    logic               ready;
    sss_pkg::in_item_t  item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface sss_rsp_if;
    logic               valid;
    logic               ready;
    sss_pkg::out_item_t item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface sss_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/sss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hdl/sequenced_sample_store_top.sv
// Sequenced sample store: per-stream sample buffer with sequence gap counting.
// Depends on sss_pkg, sss_if.sv and sss_ram.
//
// Usage
//   req : one item per request (add, find by target cycle, read last good).
//   rsp : exactly one item per request, in order.
//   cfg : writes keep_limit; ready is always high. Write only while idle.
// Steps (acceptance to result valid; the block returns to idle before the next item)
//   Add    : check, 8-slot scan through the slot RAM's single read port,
//            decide/write, output; each eviction beyond the keep limit adds
//            a rescan and an evict step.
//   Find   : check, the same slot scan, output. Last good: check, one read of
//            the last-good RAM, output. Unused action or sequence duplicate: check, output.
//   One item is worked on at a time; the scan over the slot RAM sets the rate.
// Output
//   The result sits in an output register; the next item is accepted while it
//   waits. A stalled receiver holds rsp steady and, once a second result is
//   ready, the block waits in its final state until the register frees.
// Reset
//   Valid bits, seen flags and gap counters clear at once; keep_limit is 8.
//   Record RAMs are not cleared; they are only read behind valid bits.
module sequenced_sample_store_top (
    input  logic clk,
    input  logic rst_n,
    sss_req_if.sink   req,
    sss_rsp_if.source rsp,
    sss_cfg_if.sink   cfg
);
    import sss_pkg::*;

    localparam int NSLOT = NUM_STREAMS * SLOTS_PER_STREAM;

    state_t                 state_reg, state_next;
    in_item_t               item_reg, item_next;
    logic [NUM_STREAMS-1:0] seen_reg, seen_next;
    logic [31:0]            last_seq_reg [NUM_STREAMS];
    logic [31:0]            last_seq_next [NUM_STREAMS];
    logic [47:0]            gap_cnt_reg [NUM_STREAMS];
    logic [47:0]            gap_cnt_next [NUM_STREAMS];
    logic [NSLOT-1:0]       slot_vld_reg, slot_vld_next;
    logic [NUM_STREAMS-1:0] good_vld_reg, good_vld_next;
    logic [3:0]             keep_reg, keep_next;
    logic [31:0]            gap_reg, gap_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic [SLOT_W-1:0]      rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]       nvalid_reg, nvalid_next;
    logic                   hit_reg, hit_next;
    logic [SLOT_W-1:0]      hit_idx_reg, hit_idx_next;
    logic [31:0]            hit_sq_reg, hit_sq_next;
    logic                   free_reg, free_next;
    logic [SLOT_W-1:0]      free_idx_reg, free_idx_next;
    logic                   min_reg, min_next;
    logic [SLOT_W-1:0]      min_idx_reg, min_idx_next;
    logic [31:0]            min_tc_reg, min_tc_next;
    logic                   prune_reg, prune_next;
    out_item_t              res_reg, res_next;
    logic                   out_vld_reg, out_vld_next;
    out_item_t              out_item_reg, out_item_next;

    // RAM ports
    logic              slot_we;
    logic [ADDR_W-1:0] slot_waddr, slot_raddr;
    rec_t              slot_wdata, slot_rdata;
    logic              good_we;
    logic [SID_W-1:0]  good_raddr;
    rec_t              good_rdata;

    logic [SID_W-1:0]  sid;
    rec_t              new_rec;
    logic [CNT_W-1:0]  eff_limit;
    logic [CNT_W-1:0]  new_count;
    logic [48:0]       gap_sum;
    logic              slot_v;
    logic [SLOT_W-1:0] tgt_idx;
    logic              tgt_ok;

    sss_ram #(.WIDTH(REC_W), .DEPTH(NSLOT)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    sss_ram #(.WIDTH(REC_W), .DEPTH(NUM_STREAMS)) u_good_ram (
        .clk   (clk),
        .we    (good_we),
        .waddr (item_reg.stream_id),
        .wdata (new_rec),
        .raddr (good_raddr),
        .rdata (good_rdata)
    );

    assign sid       = item_reg.stream_id;
    assign new_rec   = '{tc: item_reg.due_cycle, sq: item_reg.seq,
                         pay: item_reg.payload_tag, rt: item_reg.receive_time};
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_vld_reg;
    assign rsp.item  = out_item_reg;

    // Keep limit clamped to 1..SLOTS_PER_STREAM
    always_comb
    begin
        if (keep_reg == 4'd0)
        begin
            eff_limit = CNT_W'(1);
        end
        else if (32'(keep_reg) > SLOTS_PER_STREAM)
        begin
            eff_limit = CNT_W'(SLOTS_PER_STREAM);
        end
        else
        begin
            eff_limit = CNT_W'(keep_reg);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        seen_next     = seen_reg;
        last_seq_next = last_seq_reg;
        gap_cnt_next  = gap_cnt_reg;
        slot_vld_next = slot_vld_reg;
        good_vld_next = good_vld_reg;
        keep_next     = keep_reg;
        gap_next      = gap_reg;
        cnt_next      = cnt_reg;
        rd_vld_next   = 1'b0;
        rd_idx_next   = rd_idx_reg;
        nvalid_next   = nvalid_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_sq_next   = hit_sq_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        min_next      = min_reg;
        min_idx_next  = min_idx_reg;
        min_tc_next   = min_tc_reg;
        prune_next    = prune_reg;
        res_next      = res_reg;
        out_vld_next  = out_vld_reg;
        out_item_next = out_item_reg;
        slot_we       = 1'b0;
        slot_waddr    = {sid, min_idx_reg};
        slot_wdata    = new_rec;
        slot_raddr    = {sid, cnt_reg[SLOT_W-1:0]};
        good_we       = 1'b0;
        good_raddr    = sid;
        gap_sum       = {1'b0, gap_cnt_reg[sid]} + {17'd0, gap_reg};
        slot_v        = slot_vld_reg[{sid, rd_idx_reg}];
        new_count     = nvalid_reg + CNT_W'(free_reg && !hit_reg);
        tgt_idx       = min_idx_reg;
        tgt_ok        = 1'b0;

        if (cfg.valid)
        begin
            keep_next = cfg.data;
        end
        if (out_vld_reg && rsp.ready)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    item_next  = req.item;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                res_next    = '0;
                gap_next    = '0;
                cnt_next    = '0;
                nvalid_next = '0;
                hit_next    = 1'b0;
                free_next   = 1'b0;
                min_next    = 1'b0;
                prune_next  = 1'b0;
                case (item_reg.action)
                    ACT_ADD:
                    begin
                        if (seen_reg[sid] && item_reg.seq == last_seq_reg[sid])
                        begin
                            res_next.status = ST_DUP;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            // gap only on a forward jump of more than one
                            if (seen_reg[sid] &&
                                ({1'b0, item_reg.seq} > {1'b0, last_seq_reg[sid]} + 33'd1))
                            begin
                                gap_next = item_reg.seq - last_seq_reg[sid] - 32'd1;
                                gap_sum  = {1'b0, gap_cnt_reg[sid]} + {17'd0, gap_next};
                                gap_cnt_next[sid] = gap_sum[48] ? GAP_MAX : gap_sum[47:0];
                            end
                            state_next = S_SCAN;
                        end
                    end
                    ACT_FIND:
                    begin
                        state_next = S_SCAN;
                    end
                    ACT_GOOD:
                    begin
                        state_next = S_GOOD_RD;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_SCAN:
            begin
                // issue one read a cycle, process its data in the cycle after
                if (32'(cnt_reg) < SLOTS_PER_STREAM)
                begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = cnt_reg[SLOT_W-1:0];
                    cnt_next    = cnt_reg + CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    if (!prune_reg && item_reg.action == ACT_FIND)
                    begin
                        if (slot_v && !hit_reg && slot_rdata.tc == item_reg.due_cycle)
                        begin
                            hit_next                  = 1'b1;
                            res_next.found            = 1'b1;
                            res_next.out_due_cycle    = slot_rdata.tc;
                            res_next.out_seq          = slot_rdata.sq;
                            res_next.out_payload      = slot_rdata.pay;
                            res_next.out_receive_time = slot_rdata.rt;
                        end
                    end
                    else
                    begin
                        if (slot_v)
                        begin
                            if (!prune_reg)
                            begin
                                nvalid_next = nvalid_reg + CNT_W'(1);
                                if (slot_rdata.tc == item_reg.due_cycle)
                                begin
                                    hit_next     = 1'b1;
                                    hit_idx_next = rd_idx_reg;
                                    hit_sq_next  = slot_rdata.sq;
                                end
                            end
                            if (!min_reg || slot_rdata.tc < min_tc_reg)
                            begin
                                min_next     = 1'b1;
                                min_idx_next = rd_idx_reg;
                                min_tc_next  = slot_rdata.tc;
                            end
                        end
                        else if (!free_reg && !prune_reg)
                        begin
                            free_next     = 1'b1;
                            free_idx_next = rd_idx_reg;
                        end
                    end
                end
                if (32'(cnt_reg) == SLOTS_PER_STREAM && !rd_vld_reg)
                begin
                    if (prune_reg)
                    begin
                        state_next = S_EVICT;
                    end
                    else if (item_reg.action == ACT_ADD)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_DECIDE:
            begin
                res_next.seq_gap = gap_reg;
                if (hit_reg && hit_sq_reg == item_reg.seq)
                begin
                    // same key, same sequence number: nothing stored
                    res_next.status = ST_DUP;
                    state_next      = S_DONE;
                end
                else
                begin
                    if (hit_reg)
                    begin
                        tgt_idx = hit_idx_reg;
                        tgt_ok  = 1'b1;
                    end
                    else if (free_reg)
                    begin
                        tgt_idx = free_idx_reg;
                        tgt_ok  = 1'b1;
                        slot_vld_next[{sid, free_idx_reg}] = 1'b1;
                    end
                    else if (min_reg && min_tc_reg < item_reg.due_cycle)
                    begin
                        // full stream: the oldest entry is replaced in place
                        tgt_idx = min_idx_reg;
                        tgt_ok  = 1'b1;
                    end
                    slot_we           = tgt_ok;
                    slot_waddr        = {sid, tgt_idx};
                    res_next.inserted = 1'b1;
                    res_next.status   = (gap_reg != 32'd0) ? ST_GAP : ST_FRESH;
                    if (!seen_reg[sid] || item_reg.seq > last_seq_reg[sid])
                    begin
                        seen_next[sid]     = 1'b1;
                        last_seq_next[sid] = item_reg.seq;
                    end
                    if (item_reg.clock_valid && item_reg.producer_ok && item_reg.crc_ok)
                    begin
                        good_we            = 1'b1;
                        good_vld_next[sid] = 1'b1;
                    end
                    nvalid_next = new_count;
                    if (new_count > eff_limit)
                    begin
                        cnt_next   = '0;
                        min_next   = 1'b0;
                        prune_next = 1'b1;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_EVICT:
            begin
                slot_vld_next[{sid, min_idx_reg}] = 1'b0;
                nvalid_next = nvalid_reg - CNT_W'(1);
                cnt_next    = '0;
                min_next    = 1'b0;
                if (nvalid_next > eff_limit)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_GOOD_RD:
            begin
                if (good_vld_reg[sid])
                begin
                    res_next.found            = 1'b1;
                    res_next.out_due_cycle    = good_rdata.tc;
                    res_next.out_seq          = good_rdata.sq;
                    res_next.out_payload      = good_rdata.pay;
                    res_next.out_receive_time = good_rdata.rt;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    out_item_next           = res_reg;
                    out_item_next.gap_total = gap_cnt_reg[sid];
                    out_vld_next            = 1'b1;
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            seen_reg     <= '0;
            slot_vld_reg <= '0;
            good_vld_reg <= '0;
            keep_reg     <= 4'd8;
            out_vld_reg  <= 1'b0;
            rd_vld_reg   <= 1'b0;
            cnt_reg      <= '0;
            prune_reg    <= 1'b0;
            for (int i = 0; i < NUM_STREAMS; i++)
            begin
                gap_cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            seen_reg     <= seen_next;
            slot_vld_reg <= slot_vld_next;
            good_vld_reg <= good_vld_next;
            keep_reg     <= keep_next;
            out_vld_reg  <= out_vld_next;
            rd_vld_reg   <= rd_vld_next;
            cnt_reg      <= cnt_next;
            prune_reg    <= prune_next;
            gap_cnt_reg  <= gap_cnt_next;
        end
    end

    // payload and scan bookkeeping, no reset needed
    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        last_seq_reg  <= last_seq_next;
        gap_reg       <= gap_next;
        rd_idx_reg    <= rd_idx_next;
        nvalid_reg    <= nvalid_next;
        hit_reg       <= hit_next;
        hit_idx_reg   <= hit_idx_next;
        hit_sq_reg    <= hit_sq_next;
        free_reg      <= free_next;
        free_idx_reg  <= free_idx_next;
        min_reg       <= min_next;
        min_idx_reg   <= min_idx_next;
        min_tc_reg    <= min_tc_next;
        res_reg       <= res_next;
        out_item_reg  <= out_item_next;
    end

endmodule

// File: sim/sss_checker.sv
// Checker for the sequenced sample store: watches req, rsp and cfg, predicts each
// response from its own copy of the stream state and compares field by field.
// Depends on sss_pkg and the interfaces in hdl/sss_if.sv.
module sss_checker (
    input  logic clk,
    input  logic rst_n,
    sss_req_if.sink   req_mon,
    sss_rsp_if.sink   rsp_mon,
    sss_cfg_if.sink   cfg_mon,
    output int        fail_count,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import sss_pkg::*;

    logic [3:0]  keep_q;
    logic        seen_q   [NUM_STREAMS];
    logic [31:0] lseq_q   [NUM_STREAMS];
    logic [47:0] gaps_q   [NUM_STREAMS];
    logic        used_q   [NUM_STREAMS][SLOTS_PER_STREAM];
    rec_t        slot_q   [NUM_STREAMS][SLOTS_PER_STREAM];
    logic        gvalid_q [NUM_STREAMS];
    rec_t        good_q   [NUM_STREAMS];
    out_item_t   expected_rsp[$];

    function automatic int oldest_slot(int s);
        int best;
        best = -1;
        for (int i = 0; i < SLOTS_PER_STREAM; i++)
            if (used_q[s][i] && (best < 0 || slot_q[s][i].tc < slot_q[s][best].tc))
                best = i;
        return best;
    endfunction

    function automatic out_item_t store_response(in_item_t it);
        out_item_t o;
        rec_t      r;
        int        s, hit, freeslot, cnt, lim, m;
        logic [31:0] gap;
        logic [48:0] sum;
        o = '0;
        s = it.stream_id;
        r = '{it.due_cycle, it.seq, it.payload_tag, it.receive_time};
        gap = 0;
        hit = -1;
        freeslot = -1;
        cnt = 0;
        if (it.action == ACT_ADD) begin
            if (seen_q[s] && it.seq == lseq_q[s]) begin
                o.status = ST_DUP;
            end
            else begin
                if (seen_q[s] && {1'b0, it.seq} > {1'b0, lseq_q[s]} + 33'd1) begin
                    gap = it.seq - lseq_q[s] - 1;
                    sum = gaps_q[s] + gap;
                    gaps_q[s] = sum > GAP_MAX ? GAP_MAX : sum[47:0];
                end
                o.seq_gap = gap;
                for (int i = 0; i < SLOTS_PER_STREAM; i++) begin
                    if (used_q[s][i]) begin
                        cnt++;
                        if (slot_q[s][i].tc == r.tc) hit = i;
                    end
                    else if (freeslot < 0) freeslot = i;
                end
                if (hit >= 0 && slot_q[s][hit].sq == r.sq) begin
                    o.status = ST_DUP;
                end
                else begin
                    if (hit >= 0) slot_q[s][hit] = r;
                    else if (freeslot >= 0) begin
                        used_q[s][freeslot] = 1'b1;
                        slot_q[s][freeslot] = r;
                        cnt++;
                    end
                    else begin
                        m = oldest_slot(s);
                        if (m >= 0 && slot_q[s][m].tc < r.tc) slot_q[s][m] = r;
                    end
                    o.inserted = 1'b1;
                    o.status = gap != 0 ? ST_GAP : ST_FRESH;
                    if (!seen_q[s] || it.seq > lseq_q[s]) begin
                        seen_q[s] = 1'b1;
                        lseq_q[s] = it.seq;
                    end
                    if (it.clock_valid && it.producer_ok && it.crc_ok) begin
                        gvalid_q[s] = 1'b1;
                        good_q[s] = r;
                    end
                    lim = keep_q == 0 ? 1 : (keep_q > SLOTS_PER_STREAM ? SLOTS_PER_STREAM
                                                                       : keep_q);
                    while (cnt > lim) begin
                        m = oldest_slot(s);
                        used_q[s][m] = 1'b0;
                        cnt--;
                    end
                end
            end
        end
        else if (it.action == ACT_FIND) begin
            for (int i = 0; i < SLOTS_PER_STREAM; i++)
                if (!o.found && used_q[s][i] && slot_q[s][i].tc == r.tc) begin
                    o.found = 1'b1;
                    {o.out_due_cycle, o.out_seq, o.out_payload, o.out_receive_time}
                        = slot_q[s][i];
                end
        end
        else if (it.action == ACT_GOOD && gvalid_q[s]) begin
            o.found = 1'b1;
            {o.out_due_cycle, o.out_seq, o.out_payload, o.out_receive_time} = good_q[s];
        end
        o.gap_total = gaps_q[s];
        return o;
    endfunction

    assign pending = expected_rsp.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want, got;
        if (!rst_n) begin
            keep_q <= 4'd8;
            fail_count <= 0;
            expected_rsp.delete();
            for (int s = 0; s < NUM_STREAMS; s++) begin
                seen_q[s] = 0; lseq_q[s] = 0; gaps_q[s] = 0; gvalid_q[s] = 0;
                good_q[s] = '0;
                for (int i = 0; i < SLOTS_PER_STREAM; i++) begin
                    used_q[s][i] = 0; slot_q[s][i] = '0;
                end
            end
        end
        else begin
            if (cfg_mon.valid && cfg_mon.ready) keep_q <= cfg_mon.data;
            if (req_mon.valid && req_mon.ready)
                expected_rsp.push_back(store_response(req_mon.item));
            if (rsp_mon.valid && rsp_mon.ready) begin
                got = rsp_mon.item;
                if (expected_rsp.size() == 0) begin
                    if (fail_count < 10) $display("unexpected response %p", got);
                    fail_count <= fail_count + 1;
                end
                else begin
                    want = expected_rsp.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10)
                            $display("mismatch: expected %p, actual %p", want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// File: sim/tb_sequenced_sample_store_top.sv
// Testbench top for sequenced_sample_store_top: clock, reset, stimulus, verdict.
// Depends on sss_pkg, hdl/sss_if.sv, the block itself and sim/sss_checker.sv.
module tb_sequenced_sample_store_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sss_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count, pending;
    int   cycle_count = 0;

    sss_req_if req ();
    sss_rsp_if rsp ();
    sss_cfg_if cfg ();

    sequenced_sample_store_top uut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
                                    .cfg(cfg));
    sss_checker chk (.clk(clk), .rst_n(rst_n), .req_mon(req), .rsp_mon(rsp),
                     .cfg_mon(cfg), .fail_count(fail_count), .pending(pending));

    always #5 clk = ~clk;

    // Generous cycle limit for ~1150 items, receiver stalls included.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000) begin
            $display("** sequenced_sample_store_top: FAILED **");
            $finish;
        end
    end

    // Receiver stall pattern: mode changes now and then; some stretches never stall.
    int stall_mode = 0;
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= ($urandom_range(0, 3) != 0);
            2: rsp.ready <= ($urandom_range(0, 3) == 0);
            default: rsp.ready <= cycle_count[3];
        endcase
    end

    // Stream pool: few streams so keys and sequence numbers collide often.
    int          next_seq [NUM_STREAMS];
    logic [31:0] base_tc  [NUM_STREAMS];
    int          burst_left = 0;

    // Send one item; bursts of random length separated by random gaps.
    // valid stays high within a burst and drops after the last item of it.
    task automatic send_item(in_item_t it);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        req.valid <= 1'b1;
        req.item  <= it;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        if (burst_left == 0) req.valid <= 1'b0;
    endtask

    task automatic send_fields(logic [1:0] act, int s, logic [31:0] tc, logic [31:0] sq,
                               logic [2:0] flags);
        in_item_t it;
        it.action = act;
        it.stream_id = SID_W'(s);
        it.due_cycle = tc;
        it.seq = sq;
        it.payload_tag = $urandom;
        it.receive_time = {$urandom, $urandom};
        {it.clock_valid, it.producer_ok, it.crc_ok} = flags;
        send_item(it);
    endtask

    // Mostly well-formed traffic per stream: rising seq, nearby keys, some gaps.
    task automatic random_item();
        in_item_t it;
        int s, r;
        s = $urandom_range(0, 3) == 0 ? $urandom_range(0, NUM_STREAMS - 1)
                                      : $urandom_range(0, 3);
        r = $urandom_range(0, 99);
        it.action = r < 55 ? ACT_ADD : (r < 80 ? ACT_FIND : (r < 95 ? ACT_GOOD : ACT_UNUSED));
        it.stream_id = SID_W'(s);
        it.due_cycle = base_tc[s] + $urandom_range(0, 11);
        if ($urandom_range(0, 29) == 0) it.due_cycle = $urandom;
        r = $urandom_range(0, 99);
        if (r < 60) next_seq[s]++;
        else if (r < 75) next_seq[s] += $urandom_range(2, 20);
        it.seq = r < 85 ? next_seq[s] : (r < 95 ? next_seq[s] - $urandom_range(0, 3)
                                                : $urandom);
        if (it.action == ACT_ADD && $urandom_range(0, 3) == 0) base_tc[s]++;
        it.payload_tag = $urandom;
        it.receive_time = {$urandom, $urandom};
        it.clock_valid = $urandom_range(0, 5) != 0;
        it.producer_ok = $urandom_range(0, 5) != 0;
        it.crc_ok = $urandom_range(0, 5) != 0;
        send_item(it);
    endtask

    // Close any open burst, wait for all responses, then idle a while.
    task automatic drain();
        if (burst_left != 0) begin
            req.valid <= 1'b0;
            burst_left = 0;
        end
        while (pending != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_keep(logic [3:0] v);
        cfg.valid <= 1'b1;
        cfg.data  <= v;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    initial
    begin
        logic [3:0] keeps [6];
        keeps = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd5};
        req.valid = 1'b0;
        req.item = '0;
        rsp.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        for (int s = 0; s < NUM_STREAMS; s++)
        begin
            next_seq[s] = $urandom_range(0, 1000);
            base_tc[s] = $urandom;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: lookups on empty state, field extremes, dup, gap, wrap, action 3.
        send_fields(ACT_FIND, 0, 32'h0, 32'h0, 3'b000);
        send_fields(ACT_GOOD, 15, 32'hFFFF_FFFF, 32'h0, 3'b000);
        send_fields(ACT_ADD, 15, 32'hFFFF_FFFF, 32'h0, 3'b111);
        send_fields(ACT_ADD, 15, 32'h0, 32'h0, 3'b111);          // seq duplicate
        send_fields(ACT_ADD, 15, 32'h0, 32'hFFFF_FFFF, 3'b110);  // huge gap
        send_fields(ACT_ADD, 15, 32'h0, 32'h5, 3'b101);          // older seq, fresh
        send_fields(ACT_ADD, 15, 32'h0, 32'h5, 3'b011);          // key duplicate
        send_fields(ACT_FIND, 15, 32'h0, 32'h0, 3'b000);
        send_fields(ACT_GOOD, 15, 32'h0, 32'h0, 3'b000);
        send_fields(ACT_UNUSED, 15, 32'h0, 32'h0, 3'b111);
        send_fields(ACT_ADD, 1, 32'd10, 32'd100, 3'b111);
        send_fields(ACT_ADD, 1, 32'd10, 32'd105, 3'b111);        // gap, overwrite
        send_fields(ACT_ADD, 1, 32'd20, 32'd105, 3'b111);        // seq duplicate
        send_fields(ACT_ADD, 1, 32'd30, 32'd103, 3'b111);
        send_fields(ACT_FIND, 1, 32'd10, 32'd0, 3'b000);
        send_fields(ACT_FIND, 1, 32'd11, 32'd0, 3'b000);
        drain();

        // Phases at several keep limits, extremes included; full-stream eviction
        // at a small limit and at the full depth.
        foreach (keeps[k])
        begin
            write_keep(keeps[k]);
            for (int n = 0; n < 180; n++) random_item();
            // fill one stream past its depth with falling keys
            for (int n = 0; n < 10; n++)
                send_fields(ACT_ADD, 2, base_tc[2] + 40 - 3 * n, next_seq[2] + n + 1, 3'b111);
            next_seq[2] += 10;
            drain();
        end

        if (fail_count == 0)
            $display("** sequenced_sample_store_top: PASSED **");
        else
            $display("** sequenced_sample_store_top: FAILED **");
        $finish;
    end
endmodule
